[rtl/hbs_pkg.sv]
`timescale 1ns / 1ps
package hbs_pkg;

   localparam int KeyW = 20;
   localparam int WordW = 32;
   localparam int LeafDepth = 32768;
   localparam int MidDepth = 1024;
   localparam int LeafAw = 15;
   localparam int MidAw = 10;

   typedef enum logic [3:0] {
      OP_INSERT = 4'd0,
      OP_DELETE = 4'd1,
      OP_TEST   = 4'd2,
      OP_MIN    = 4'd3,
      OP_MAX    = 4'd4,
      OP_PRED   = 4'd5,
      OP_SUCC   = 4'd6,
      OP_CLEAR  = 4'd7,
      OP_FILL   = 4'd8
   } op_type;

   // lowest set bit index (0 when word is zero)
   function automatic logic [4:0] low_bit(input logic [WordW-1:0] w);
      logic [4:0] b;
      b = 5'd0;
      for (int i = WordW - 1; i >= 0; i--) begin
         if (w[i]) b = 5'(i);
      end
      return b;
   endfunction

   // highest set bit index (0 when word is zero)
   function automatic logic [4:0] high_bit(input logic [WordW-1:0] w);
      logic [4:0] b;
      b = 5'd0;
      for (int i = 0; i < WordW; i++) begin
         if (w[i]) b = 5'(i);
      end
      return b;
   endfunction

endpackage

[rtl/hbs_ram.sv]
`timescale 1ns / 1ps
module hbs_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/hierarchical_bitmap_set.sv]
`timescale 1ns / 1ps
// Channel   Dir  Ports                 Contents
// request   in   req_tvalid/tready     tdata[3:0] kind, tdata[23:4] key
// response  out  rsp_tvalid/tready     tdata[0] found, tdata[20:1] result_key
//
// Leaf and level-1 words sit in single-port-per-side RAMs; levels 2 and 3
// are flops. Each item passes RD0 and UPD, then DONE for test/insert/delete
// and leaf-word pred/succ, DN0 for mid-word pred/succ, or DN1, WAIT and DN0
// for min/max and level-2/3 pred/succ, then RSP. After reset a clearing pass
// over every leaf address zeroes the RAMs; clear and fill run the same sweep
// before they answer. The request side stalls while an item is in progress
// and until its result is taken.
module hierarchical_bitmap_set
   import hbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // kind[3:0], key[23:4]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // found[0], result_key[20:1], zero pad
);

   typedef enum logic [8:0] {
      ST_SWEEP = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_RD0   = 9'b000000100,  // leaf and mid read issued
      ST_UPD   = 9'b000001000,  // data back, decide
      ST_DN1   = 9'b000010000,  // mid word read for descent
      ST_DN0   = 9'b000100000,  // leaf word read for descent
      ST_DONE  = 9'b001000000,
      ST_RSP   = 9'b010000000,
      ST_WAIT  = 9'b100000000
   } state_type;

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [KeyW-1:0]  key_ff, key_in;
   logic [KeyW-1:0]  res_ff, res_in;
   logic             fnd_ff, fnd_in;
   logic             hi_ff, hi_in;      // descend along highest bits
   logic [LeafAw:0]  swp_ff, swp_in;
   logic             fillv_ff, fillv_in;
   logic [WordW-1:0] upper_ff [32];
   logic [WordW-1:0] top_ff, top_in;
   logic             upw_en;
   logic [4:0]       upw_addr;
   logic [WordW-1:0] upw_data;
   logic             ov_ff, ov_in;
   logic [23:0]      od_ff, od_in;

   logic              lwe, mwe;
   logic [LeafAw-1:0] lwa, lra;
   logic [MidAw-1:0]  mwa, mra;
   logic [WordW-1:0]  lwd, mwd, lrd, mrd;

   hbs_ram #(.Width(WordW), .Depth(LeafDepth)) u_leaf (
      .clock, .wr_en(lwe), .wr_addr(lwa), .wr_data(lwd), .rd_addr(lra), .rd_data(lrd));
   hbs_ram #(.Width(WordW), .Depth(MidDepth)) u_mid (
      .clock, .wr_en(mwe), .wr_addr(mwa), .wr_data(mwd), .rd_addr(mra), .rd_data(mrd));

   logic [4:0]       b0, b1, b2, b3;
   logic [WordW-1:0] uw, lnew, mnew, unew, tnew, m0, m1, m2, m3;

   assign b0 = key_ff[4:0];
   assign b1 = key_ff[9:5];
   assign b2 = key_ff[14:10];
   assign b3 = key_ff[19:15];
   assign uw = upper_ff[b3];

   assign req_tready = (state_ff == ST_IDLE) && !ov_ff;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      res_in   = res_ff;
      fnd_in   = fnd_ff;
      hi_in    = hi_ff;
      swp_in   = swp_ff;
      fillv_in = fillv_ff;
      top_in   = top_ff;
      upw_en   = 1'b0;
      upw_addr = b3;
      upw_data = '0;
      ov_in    = ov_ff && !rsp_tready;
      od_in    = od_ff;
      lwe = 1'b0; lwa = key_ff[19:5]; lwd = '0; lra = key_ff[19:5];
      mwe = 1'b0; mwa = key_ff[19:10]; mwd = '0; mra = key_ff[19:10];
      lnew = '0; mnew = '0; unew = '0; tnew = '0;
      m0 = '0; m1 = '0; m2 = '0; m3 = '0;

      unique case (state_ff)
         // zero or fill every RAM word, one address a cycle
         ST_SWEEP: begin
            lwe = 1'b1;
            lwa = swp_ff[LeafAw-1:0];
            lwd = {WordW{fillv_ff}};
            mwe = (swp_ff[LeafAw-1:MidAw] == '0);
            mwa = swp_ff[MidAw-1:0];
            mwd = {WordW{fillv_ff}};
            swp_in = swp_ff + (LeafAw+1)'(1);
            if (swp_ff == (LeafAw+1)'(LeafDepth - 1)) begin
               state_in = (op_ff == OP_CLEAR || op_ff == OP_FILL) ? ST_RSP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid && !ov_ff) begin
               op_in    = op_type'(req_tdata[3:0]);
               key_in   = req_tdata[23:4];
               lra      = req_tdata[23:9];
               mra      = req_tdata[23:14];
               fnd_in   = 1'b0;
               res_in   = '0;
               state_in = ST_RD0;
            end
         end
         ST_RD0: state_in = ST_UPD;
         ST_UPD: begin
            state_in = ST_DONE;
            unique case (op_ff)
               OP_INSERT: begin
                  fnd_in = lrd[b0];
                  lnew = lrd; lnew[b0] = 1'b1;
                  mnew = mrd; mnew[b1] = 1'b1;
                  unew = uw;  unew[b2] = 1'b1;
                  tnew = top_ff; tnew[b3] = 1'b1;
                  lwe = 1'b1; lwd = lnew;
                  mwe = 1'b1; mwd = mnew;
                  upw_en = 1'b1; upw_data = unew;
                  top_in = tnew;
               end
               OP_DELETE: begin
                  fnd_in = lrd[b0];
                  if (lrd[b0]) begin
                     lnew = lrd; lnew[b0] = 1'b0;
                     mnew = mrd; mnew[b1] = 1'b0;
                     unew = uw;  unew[b2] = 1'b0;
                     tnew = top_ff; tnew[b3] = 1'b0;
                     lwe = 1'b1; lwd = lnew;
                     if (lnew == '0) begin
                        mwe = 1'b1; mwd = mnew;
                        if (mnew == '0) begin
                           upw_en = 1'b1; upw_data = unew;
                           if (unew == '0) top_in = tnew;
                        end
                     end
                  end
               end
               OP_TEST: fnd_in = lrd[b0];
               OP_CLEAR: begin
                  fnd_in = lrd[b0];
                  top_in = '0;
                  // upper words are cleared in the sequential block
                  fillv_in = 1'b0; swp_in = '0; state_in = ST_SWEEP;
               end
               OP_FILL: begin
                  top_in = '1;
                  fillv_in = 1'b1; swp_in = '0; state_in = ST_SWEEP;
               end
               OP_MIN, OP_MAX: begin
                  if (top_ff != '0) begin
                     fnd_in = 1'b1;
                     hi_in  = (op_ff == OP_MAX);
                     res_in[19:15] = hi_in ? high_bit(top_ff) : low_bit(top_ff);
                     res_in[14:10] = hi_in ? high_bit(upper_ff[res_in[19:15]])
                                           : low_bit(upper_ff[res_in[19:15]]);
                     mra = res_in[19:10];
                     state_in = ST_DN1;
                  end
               end
               OP_PRED, OP_SUCC: begin
                  hi_in = (op_ff == OP_PRED);
                  if (op_ff == OP_SUCC) begin
                     m0 = lrd & (32'hFFFFFFFE << b0);
                     m1 = mrd & (32'hFFFFFFFE << b1);
                     m2 = uw & (32'hFFFFFFFE << b2);
                     m3 = top_ff & (32'hFFFFFFFE << b3);
                  end else begin
                     m0 = lrd & ((32'd1 << b0) - 32'd1);
                     m1 = mrd & ((32'd1 << b1) - 32'd1);
                     m2 = uw & ((32'd1 << b2) - 32'd1);
                     m3 = top_ff & ((32'd1 << b3) - 32'd1);
                  end
                  // nearest level with a candidate, then descend the other way
                  priority if (m0 != '0) begin
                     fnd_in = 1'b1;
                     res_in = {key_ff[19:5], hi_in ? high_bit(m0) : low_bit(m0)};
                  end else if (m1 != '0) begin
                     fnd_in = 1'b1;
                     res_in = {key_ff[19:10], hi_in ? high_bit(m1) : low_bit(m1), 5'd0};
                     lra = res_in[19:5];
                     state_in = ST_DN0;
                  end else if (m2 != '0) begin
                     fnd_in = 1'b1;
                     res_in = {b3, hi_in ? high_bit(m2) : low_bit(m2), 10'd0};
                     mra = res_in[19:10];
                     state_in = ST_DN1;
                  end else if (m3 != '0) begin
                     fnd_in = 1'b1;
                     res_in[19:15] = hi_in ? high_bit(m3) : low_bit(m3);
                     res_in[14:10] = hi_in ? high_bit(upper_ff[res_in[19:15]])
                                           : low_bit(upper_ff[res_in[19:15]]);
                     res_in[9:0] = '0;
                     mra = res_in[19:10];
                     state_in = ST_DN1;
                  end else begin
                     fnd_in = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         // hold the descent address so the read data stays put
         ST_DN1: begin
            mra = res_ff[19:10];
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            res_in[9:5] = hi_ff ? high_bit(mrd) : low_bit(mrd);
            lra = res_in[19:5];
            state_in = ST_DN0;
         end
         ST_DN0: begin
            lra = res_ff[19:5];
            state_in = ST_RSP;
         end
         ST_DONE: state_in = ST_RSP;
         ST_RSP: begin
            // leaf data valid here only after a DN0 read
            if (op_ff == OP_MIN || op_ff == OP_MAX ||
                ((op_ff == OP_PRED || op_ff == OP_SUCC) && res_in[4:0] == 5'd0 && fnd_ff &&
                 !(key_ff[19:5] == res_ff[19:5]))) begin
               res_in[4:0] = hi_ff ? high_bit(lrd) : low_bit(lrd);
            end
            if (op_ff == OP_FILL) fnd_in = 1'b0;
            if (!fnd_in) res_in = '0;
            ov_in = 1'b1;
            od_in = {3'd0, res_in, fnd_in};
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         swp_ff   <= '0;
         fillv_ff <= 1'b0;
         op_ff    <= OP_TEST;
         ov_ff    <= 1'b0;
         top_ff   <= '0;
         for (int i = 0; i < 32; i++) upper_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         swp_ff   <= swp_in;
         fillv_ff <= fillv_in;
         op_ff    <= op_in;
         ov_ff    <= ov_in;
         top_ff   <= top_in;
         if (state_ff == ST_UPD && (op_ff == OP_CLEAR || op_ff == OP_FILL)) begin
            for (int i = 0; i < 32; i++) upper_ff[i] <= {WordW{op_ff == OP_FILL}};
         end else if (upw_en) begin
            upper_ff[upw_addr] <= upw_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      res_ff <= res_in;
      fnd_ff <= fnd_in;
      hi_ff  <= hi_in;
      od_ff  <= od_in;
   end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
   import hbs_pkg::*;

   // scoreboard: keeps its own copy of the bitmap tree and the queue of
   // expected answers
   class set_scoreboard;
      bit [31:0] leaf[32768];
      bit [31:0] mid[1024];
      bit [31:0] upper[32];
      bit [31:0] top;
      bit        want_found[$];
      bit [19:0] want_key[$];
      int        errors;
      int        checked;

      function void wipe();
         foreach (leaf[i]) leaf[i] = '0;
         foreach (mid[i]) mid[i] = '0;
         foreach (upper[i]) upper[i] = '0;
         top = '0;
      endfunction

      function bit [31:0] rd(int lvl, bit [19:0] idx);
         case (lvl)
            0: return leaf[idx[14:0]];
            1: return mid[idx[9:0]];
            2: return upper[idx[4:0]];
            default: return top;
         endcase
      endfunction

      function void wr(int lvl, bit [19:0] idx, bit [31:0] w);
         case (lvl)
            0: leaf[idx[14:0]] = w;
            1: mid[idx[9:0]] = w;
            2: upper[idx[4:0]] = w;
            default: top = w;
         endcase
      endfunction

      function bit [4:0] lo_set(bit [31:0] w);
         for (int b = 0; b < 32; b++) if (w[b]) return b[4:0];
         return 5'd31;
      endfunction

      function bit [4:0] hi_set(bit [31:0] w);
         for (int b = 31; b >= 0; b--) if (w[b]) return b[4:0];
         return 5'd0;
      endfunction

      // walk the lowest or highest set bits down to a leaf key
      function bit [19:0] walk_down(int lvl, bit [19:0] idx, bit highest);
         bit [31:0] w;
         for (int l = lvl; l >= 0; l--) begin
            w = rd(l, idx);
            idx = {idx[14:0], highest ? hi_set(w) : lo_set(w)};
         end
         return idx;
      endfunction

      function bit has(bit [19:0] x);
         bit [31:0] w;
         w = leaf[x[19:5]];
         return w[x[4:0]];
      endfunction

      // strict neighbour; climb until a candidate bit exists
      function bit neighbour(bit [19:0] x, bit up, output bit [19:0] res);
         bit [19:0] idx;
         bit [31:0] w;
         bit [4:0]  pos;
         bit [19:0] child;
         res = '0;
         for (int l = 0; l < 4; l++) begin
            idx = x >> (5 * (l + 1));
            pos = 5'(x >> (5 * l));
            w = rd(l, idx) & (up ? (32'hFFFF_FFFE << pos) : ((32'd1 << pos) - 32'd1));
            if (w != 0) begin
               child = {idx[14:0], up ? lo_set(w) : hi_set(w)};
               res = (l == 0) ? child : walk_down(l - 1, child, !up);
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_request(bit [3:0] kind, bit [19:0] x);
         bit        f;
         bit [19:0] k;
         bit [31:0] w;
         bit        nonempty;
         f = 0;
         k = '0;
         nonempty = top != 0;
         case (kind)
            OP_INSERT: begin
               f = has(x);
               for (int l = 0; l < 4; l++) begin
                  w = rd(l, x >> (5 * (l + 1)));
                  w[5'(x >> (5 * l))] = 1'b1;
                  wr(l, x >> (5 * (l + 1)), w);
               end
            end
            OP_DELETE: begin
               f = has(x);
               if (f) begin
                  for (int l = 0; l < 4; l++) begin
                     w = rd(l, x >> (5 * (l + 1)));
                     w[5'(x >> (5 * l))] = 1'b0;
                     wr(l, x >> (5 * (l + 1)), w);
                     if (w != 0) break;
                  end
               end
            end
            OP_TEST: f = has(x);
            OP_MIN: if (nonempty) begin f = 1; k = walk_down(3, 0, 0); end
            OP_MAX: if (nonempty) begin f = 1; k = walk_down(3, 0, 1); end
            OP_PRED: f = neighbour(x, 0, k);
            OP_SUCC: f = neighbour(x, 1, k);
            OP_CLEAR: begin f = has(x); wipe(); end
            OP_FILL: begin
               foreach (leaf[i]) leaf[i] = '1;
               foreach (mid[i]) mid[i] = '1;
               foreach (upper[i]) upper[i] = '1;
               top = '1;
            end
            default: ;
         endcase
         if (!f) k = '0;
         want_found = {want_found, f};
         want_key = {want_key, k};
      endfunction

      function void check_answer(bit [23:0] d);
         bit        f;
         bit [19:0] k;
         if (want_found.size() == 0) begin
            $display("%0t: unexpected result expected none actual %h", $time, d);
            errors++;
            return;
         end
         f = want_found.pop_front();
         k = want_key.pop_front();
         checked++;
         if (d[0] !== f || d[20:1] !== k || d[23:21] !== 3'b0) begin
            $display("%0t: mismatch expected found=%0d key=%h actual found=%0d key=%h pad=%0h",
                     $time, f, k, d[0], d[20:1], d[23:21]);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;

   set_scoreboard sb = new();
   int  send_idle = 0;
   int  recv_idle = 0;
   bit  hold_rx = 0;
   int  cycles = 0;
   int  sent = 0;
   int  n_fill = 0;

   always #5 clock = ~clock;

   hierarchical_bitmap_set u_top (.*);

   // accepted items are noted at the rising edge
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_tvalid && req_tready) sb.note_request(req_tdata[3:0], req_tdata[23:4]);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_answer(rsp_tdata);
   end

   // receiver readiness
   always @(negedge clock)
      rsp_tready <= !hold_rx && ($urandom_range(99) >= recv_idle);

   // timeout: fills and clears each sweep every RAM address
   always @(posedge clock) begin
      if (cycles > 3000000) begin
         $display("hierarchical_bitmap_set verification failed");
         $finish;
      end
   end

   // valid stays up between items sent back to back; dropped while idling
   task automatic send(input bit [3:0] kind, input bit [19:0] x);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {x, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (kind == OP_FILL || kind == OP_CLEAR) n_fill++;
      sent++;
   endtask

   task automatic drain();
      while (sb.want_found.size() != 0) @(negedge clock);
   endtask

   // random key, mostly clustered so that searches find neighbours
   function automatic bit [19:0] pick_key(bit [19:0] base);
      case ($urandom_range(3))
         0: return 20'($urandom);
         1: return base ^ 20'($urandom_range(63));
         2: return {base[19:10], 10'($urandom)};
         default: return $urandom_range(1) ? 20'(20'hFFFFF - $urandom_range(40))
                                           : 20'($urandom_range(40));
      endcase
   endfunction

   task automatic random_phase(int n);
      bit [19:0] base;
      int        r;
      bit [3:0]  kind;
      base = 20'($urandom);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(15) == 0) base = 20'($urandom);
         r = $urandom_range(999);
         if (r < 300) kind = OP_INSERT;
         else if (r < 450) kind = OP_DELETE;
         else if (r < 550) kind = OP_TEST;
         else if (r < 600) kind = OP_MIN;
         else if (r < 650) kind = OP_MAX;
         else if (r < 800) kind = OP_PRED;
         else if (r < 960) kind = OP_SUCC;
         else if (r < 972) kind = 4'($urandom_range(9, 15));
         else if (r < 976) kind = OP_CLEAR;
         else if (r < 977) kind = OP_FILL;
         else kind = OP_TEST;
         send(kind, pick_key(base));
      end
      req_tvalid <= 0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      sb.wipe();

      // directed: empty-set searches, extremes, every operation
      send(OP_MIN, 0);
      send(OP_MAX, 0);
      send(OP_PRED, 20'hFFFFF);
      send(OP_SUCC, 0);
      send(OP_INSERT, 0);
      send(OP_INSERT, 20'hFFFFF);
      send(OP_INSERT, 0);
      send(OP_MIN, 0);
      send(OP_MAX, 0);
      send(OP_PRED, 0);
      send(OP_SUCC, 20'hFFFFF);
      send(OP_SUCC, 0);
      send(OP_PRED, 20'hFFFFF);
      send(OP_INSERT, 20'h5A5A5);
      send(OP_PRED, 20'h5A5A6);
      send(OP_SUCC, 20'h5A5A4);
      send(OP_DELETE, 20'h5A5A5);
      send(OP_DELETE, 20'h5A5A5);
      send(OP_TEST, 20'hFFFFF);
      send(4'd15, 20'hAAAAA);
      send(OP_FILL, 20'h55555);
      send(OP_DELETE, 20'h12345);
      send(OP_PRED, 20'h12346);
      send(OP_SUCC, 20'h12344);
      send(OP_CLEAR, 20'h00001);
      send(OP_MAX, 0);

      // receiver stalls for a long stretch while items keep coming
      hold_rx = 1;
      fork
         begin repeat (300) @(negedge clock); hold_rx = 0; end
         random_phase(20);
      join
      drain();

      send_idle = 21; recv_idle = 84;
      random_phase(500);
      drain();
      send_idle = 84; recv_idle = 21;
      random_phase(500);
      send_idle = 0; recv_idle = 0;
      random_phase(500);

      drain();
      repeat (50) @(negedge clock);
      $display("Ran %0d items (%0d sweeps), %0d results checked.", sent, n_fill, sb.checked);
      $display("Covered all operations, empty/full sets, extremes, stalls and gaps.");
      if (sb.errors == 0 && sb.want_found.size() == 0)
         $display("hierarchical_bitmap_set verification clean");
      else
         $display("hierarchical_bitmap_set verification failed");
      $finish;
   end

endmodule
